@@ src/csg_pkg.sv @@
// shared types and constants for the combinatorial sequence generator
// no dependencies
package csg_pkg;

    localparam int MAX_ITEMS_DEF = 16;
    localparam int MAX_PICKS_DEF = 8;

    localparam logic [1:0] MODE_WORDS = 2'd0;
    localparam logic [1:0] MODE_PERM  = 2'd1;
    localparam logic [1:0] MODE_COMB  = 2'd2;
    localparam logic [1:0] MODE_MULTI = 2'd3;

    localparam logic [1:0] REQ_ADVANCE = 2'd0;
    localparam logic [1:0] REQ_RESTART = 2'd1;
    localparam logic [1:0] REQ_WRITE   = 2'd2;
    localparam logic [1:0] REQ_NONE    = 2'd3;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_ITEMS = 2'd1;
    localparam logic [1:0] CFG_PICKS = 2'd2;

    typedef struct packed {
        logic [3:0]  position_index;
        logic [31:0] item_value;
        logic        last;
        logic        wrapped;
        logic        error;
    } result_t;

endpackage

@@ src/csg_engine.sv @@
// arrangement engine: position store and a sequencer that walks the positions, busy until done
// depends on csg_pkg
module csg_engine
    import csg_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int MAX_PICKS = MAX_PICKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr,
    input  logic [1:0]  mode,
    input  logic [4:0]  item_count,
    input  logic [3:0]  pick_count,
    input  logic        start,
    input  logic        restart,
    output logic        busy,
    output logic        done,
    output logic        wrapped,
    input  logic [3:0]  rd_sel,
    output logic [3:0]  rd_pos
);

    localparam int PW = $clog2(MAX_PICKS) + 1;
    localparam int IW = 4;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;
    localparam logic [3:0] ST_FILL  = 4'd3;
    localparam logic [3:0] ST_PMOB  = 4'd4;
    localparam logic [3:0] ST_PFLIP = 4'd5;
    localparam logic [3:0] ST_PSRT  = 4'd6;
    localparam logic [3:0] ST_DONE  = 4'd7;
    localparam logic [3:0] ST_PSWP  = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [IW-1:0] pos_reg [MAX_PICKS];
    logic          dir_reg [MAX_PICKS];
    logic [PW-1:0] mob_reg;
    logic [PW-1:0] i_reg;
    logic [PW-1:0] j_reg;
    logic          wrap_reg;
    logic          pcomb_reg;
    logic [IW-1:0] moved_reg, grt_reg;
    logic          sw_reg;
    logic [PW-1:0] best_reg;

    logic [PW-1:0] k;
    logic [5:0]    n;
    assign k = PW'(pick_count);
    assign n = 6'(item_count);

    logic [PW-1:0] im1;
    assign im1 = i_reg - PW'(1);

    assign busy    = state_reg != ST_IDLE;
    assign done    = state_reg == ST_DONE;
    assign wrapped = wrap_reg;
    assign rd_pos  = 4'(pos_reg[rd_sel[PW-2:0]]);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = restart ? ST_INIT : ST_SCAN;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = state_reg;
        endcase
    end

    // shared unit: one state machine compares and updates the positions for every mode
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            state_reg <= ST_IDLE;
            wrap_reg  <= 1'b0;
            for (int p = 0; p < MAX_PICKS; p++) begin
                pos_reg[p] <= (cfg_wr && (mode == MODE_PERM || mode == MODE_COMB)
                               && p < int'(k) && item_count != 0 && k != 0
                               && int'(item_count) <= MAX_ITEMS && int'(k) <= MAX_PICKS
                               && 5'(k) <= item_count) ? IW'(p) : '0;
                dir_reg[p] <= 1'b0;
            end
            mob_reg <= (cfg_wr && item_count != 0 && k != 0) ? k - PW'(1) : '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        wrap_reg  <= 1'b0;
                        pcomb_reg <= 1'b0;
                        if (!restart) begin
                            if (mode == MODE_PERM) begin
                                if (k < PW'(2) || mob_reg >= k ||
                                    (dir_reg[mob_reg[PW-2:0]] && mob_reg + PW'(1) >= k) ||
                                    (!dir_reg[mob_reg[PW-2:0]] && mob_reg == '0)) begin
                                    state_reg <= ST_PSRT;
                                    i_reg     <= PW'(1);
                                    j_reg     <= PW'(1);
                                end else begin
                                    state_reg <= ST_PSWP;
                                end
                            end else begin
                                state_reg <= ST_SCAN;
                                i_reg     <= k;
                            end
                        end else begin
                            state_reg <= ST_INIT;
                        end
                    end
                end
                ST_INIT: begin
                    for (int p = 0; p < MAX_PICKS; p++) begin
                        pos_reg[p] <= (mode == MODE_PERM || mode == MODE_COMB) &&
                                      p < int'(k) ? IW'(p) : '0;
                        dir_reg[p] <= 1'b0;
                    end
                    mob_reg   <= k - PW'(1);
                    state_reg <= ST_DONE;
                end
                ST_SCAN: begin
                    // carry walk from the last position toward the first
                    if (i_reg == '0) begin
                        wrap_reg <= 1'b1;
                        for (int p = 0; p < MAX_PICKS; p++)
                            pos_reg[p] <= (mode == MODE_WORDS || mode == MODE_MULTI ||
                                           p >= int'(k)) ? '0 : IW'(p);
                        state_reg <= pcomb_reg ? ST_PFLIP : ST_DONE;
                    end else if (mode == MODE_WORDS) begin
                        if (6'(pos_reg[im1[PW-2:0]]) + 6'd1 < n) begin
                            pos_reg[im1[PW-2:0]] <= pos_reg[im1[PW-2:0]] + IW'(1);
                            state_reg <= ST_DONE;
                        end else begin
                            pos_reg[im1[PW-2:0]] <= '0;
                            i_reg <= im1;
                        end
                    end else if (mode == MODE_MULTI) begin
                        if (6'(pos_reg[im1[PW-2:0]]) + 6'd1 < n) begin
                            pos_reg[im1[PW-2:0]] <= pos_reg[im1[PW-2:0]] + IW'(1);
                            j_reg <= i_reg;
                            state_reg <= ST_FILL;
                        end else begin
                            i_reg <= im1;
                        end
                    end else begin
                        if (6'(pos_reg[im1[PW-2:0]]) < n - 6'(k) + 6'(im1)) begin
                            pos_reg[im1[PW-2:0]] <= pos_reg[im1[PW-2:0]] + IW'(1);
                            j_reg <= i_reg;
                            state_reg <= ST_FILL;
                        end else begin
                            i_reg <= im1;
                        end
                    end
                end
                ST_FILL: begin
                    if (j_reg >= k) begin
                        state_reg <= pcomb_reg ? ST_PFLIP : ST_DONE;
                    end else begin
                        pos_reg[j_reg[PW-2:0]] <= (mode == MODE_MULTI) ?
                            pos_reg[im1[PW-2:0]] :
                            pos_reg[j_reg[PW-2:0] - (PW-1)'(1)] + IW'(1);
                        j_reg <= j_reg + PW'(1);
                    end
                end
                ST_PSWP: begin
                    // swap mobile element with its neighbor
                    for (int p = 0; p < MAX_PICKS; p++) begin
                        if (PW'(p) == mob_reg) begin
                            if (dir_reg[p]) begin
                                pos_reg[p] <= pos_reg[(p + 1) % MAX_PICKS];
                                pos_reg[(p + 1) % MAX_PICKS] <= pos_reg[p];
                                dir_reg[p] <= dir_reg[(p + 1) % MAX_PICKS];
                                dir_reg[(p + 1) % MAX_PICKS] <= dir_reg[p];
                            end else begin
                                pos_reg[p] <= pos_reg[(p + MAX_PICKS - 1) % MAX_PICKS];
                                pos_reg[(p + MAX_PICKS - 1) % MAX_PICKS] <= pos_reg[p];
                                dir_reg[p] <= dir_reg[(p + MAX_PICKS - 1) % MAX_PICKS];
                                dir_reg[(p + MAX_PICKS - 1) % MAX_PICKS] <= dir_reg[p];
                            end
                        end
                    end
                    moved_reg <= pos_reg[mob_reg[PW-2:0]];
                    grt_reg   <= '0;
                    sw_reg    <= 1'b0;
                    best_reg  <= PW'(0);
                    i_reg     <= '0;
                    state_reg <= ST_PFLIP;
                end
                ST_PFLIP: begin
                    // after a combination step, clear directions and finish; else end or go on with the mobility scan
                    if (pcomb_reg) begin
                        for (int p = 0; p < MAX_PICKS; p++) dir_reg[p] <= 1'b0;
                        mob_reg   <= k - PW'(1);
                        state_reg <= ST_DONE;
                    end else if (i_reg >= k) begin
                        // k marks no mobile element
                        mob_reg   <= sw_reg ? best_reg : k;
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_PMOB;
                    end
                end
                ST_PMOB: begin
                    // flip direction if above the moved value, then mobility test for one position
                    logic d;
                    logic inr;
                    logic [PW-1:0] nb;
                    logic [IW-1:0] pv;
                    d   = dir_reg[i_reg[PW-2:0]];
                    pv  = pos_reg[i_reg[PW-2:0]];
                    if (pv > moved_reg) d = ~d;
                    dir_reg[i_reg[PW-2:0]] <= d;
                    if (d) begin
                        nb = i_reg + PW'(1);
                        inr = nb < k;
                    end else begin
                        nb = im1;
                        inr = i_reg != '0;
                    end
                    if (inr && pv >= grt_reg && pv > pos_reg[nb[PW-2:0]]) begin
                        grt_reg  <= pv;
                        best_reg <= i_reg;
                        sw_reg   <= 1'b1;
                    end
                    i_reg     <= i_reg + PW'(1);
                    state_reg <= ST_PFLIP;
                end
                ST_PSRT: begin
                    // insertion sort, one compare-and-shift per cycle
                    if (i_reg >= k) begin
                        pcomb_reg <= 1'b1;
                        i_reg     <= k;
                        state_reg <= ST_SCAN;
                    end else if (j_reg != '0 &&
                                 pos_reg[j_reg[PW-2:0] - (PW-1)'(1)] >
                                 pos_reg[j_reg[PW-2:0]]) begin
                        pos_reg[j_reg[PW-2:0]] <= pos_reg[j_reg[PW-2:0] - (PW-1)'(1)];
                        pos_reg[j_reg[PW-2:0] - (PW-1)'(1)] <= pos_reg[j_reg[PW-2:0]];
                        j_reg <= j_reg - PW'(1);
                    end else begin
                        i_reg <= i_reg + PW'(1);
                        j_reg <= i_reg + PW'(1);
                    end
                end
                ST_DONE: state_reg <= state_next;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ src/combinatorial_sequence_generator.sv @@
// Generator of words, combinations, k-permutations (adjacent-swap order) and
// multisets. s_tready is low while a request is worked on. An advance or
// restart is worked in the position sequencer (at the end of the k-permutation
// sequence the positions are sorted first), then the run streams out one result
// per cycle while m_tready is high, values from the value table. An invalid
// configuration gives one error result, flagged in ov_reg and then registered.
// Table writes are registered. Depends on csg_pkg and csg_engine.
module combinatorial_sequence_generator
    import csg_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int MAX_PICKS = MAX_PICKS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // req_type, table_index, table_value, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // position_index, item_value, pad
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // wrapped, error
);

    logic [1:0]  mode_reg;
    logic [4:0]  items_reg;
    logic [3:0]  picks_reg;
    logic [31:0] vtab [MAX_ITEMS];

    logic [1:0]  req_type;
    logic [3:0]  table_index;
    logic [31:0] table_value;
    assign req_type    = s_tdata[1:0];
    assign table_index = s_tdata[5:2];
    assign table_value = s_tdata[37:6];

    logic cfg_ok;
    assign cfg_ok = items_reg != 0 && picks_reg != 0 &&
                    int'(items_reg) <= MAX_ITEMS && int'(picks_reg) <= MAX_PICKS &&
                    !((mode_reg == MODE_PERM || mode_reg == MODE_COMB) &&
                      5'(picks_reg) > items_reg);

    logic        emit_reg;
    logic [3:0]  cnt_reg;
    logic        ebusy, edone, ewrap, start;
    logic [3:0]  rd_pos;
    logic        ov_reg;
    result_t     res_reg;

    assign s_tready = !ebusy && !emit_reg && !ov_reg;
    assign start = s_tvalid && s_tready && cfg_ok &&
                   (req_type == REQ_ADVANCE || req_type == REQ_RESTART);

    csg_engine #(.MAX_ITEMS(MAX_ITEMS), .MAX_PICKS(MAX_PICKS)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr(cfg_we && (cfg_index == CFG_MODE || cfg_index == CFG_ITEMS ||
                           cfg_index == CFG_PICKS)),
        .mode(cfg_index == CFG_MODE && cfg_we ? cfg_data[1:0] : mode_reg),
        .item_count(cfg_index == CFG_ITEMS && cfg_we ? cfg_data : items_reg),
        .pick_count(cfg_index == CFG_PICKS && cfg_we ? cfg_data[3:0] : picks_reg),
        .start(start), .restart(req_type == REQ_RESTART),
        .busy(ebusy), .done(edone), .wrapped(ewrap),
        .rd_sel(cnt_reg), .rd_pos(rd_pos)
    );

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready && req_type == REQ_WRITE &&
            int'(table_index) < MAX_ITEMS)
            vtab[table_index] <= table_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_WORDS;
            items_reg <= 5'd2;
            picks_reg <= 4'd1;
            emit_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            m_tvalid  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_MODE:  mode_reg  <= cfg_data[1:0];
                    CFG_ITEMS: items_reg <= cfg_data;
                    CFG_PICKS: picks_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready && !cfg_ok &&
                (req_type == REQ_ADVANCE || req_type == REQ_RESTART)) begin
                ov_reg <= 1'b1;
            end
            if (edone) begin
                emit_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            if (!m_tvalid || m_tready) begin
                if (ov_reg) begin
                    res_reg  <= '{position_index: '0, item_value: '0, last: 1'b1,
                                  wrapped: 1'b0, error: 1'b1};
                    m_tvalid <= 1'b1;
                    ov_reg   <= 1'b0;
                end else if (emit_reg) begin
                    res_reg <= '{position_index: rd_pos, item_value: vtab[rd_pos],
                                 last: (5'(cnt_reg) + 5'd1 == 5'(picks_reg)),
                                 wrapped: ewrap, error: 1'b0};
                    m_tvalid <= 1'b1;
                    cnt_reg  <= cnt_reg + 4'd1;
                    if (5'(cnt_reg) + 5'd1 == 5'(picks_reg)) emit_reg <= 1'b0;
                end else begin
                    m_tvalid <= 1'b0;
                end
            end
        end
    end

    assign m_tdata = {4'd0, res_reg.item_value, res_reg.position_index};
    assign m_tlast = res_reg.last;
    assign m_tuser = {res_reg.error, res_reg.wrapped};

endmodule

@@ src/csg_checker.sv @@
// port-level checks for the combinatorial sequence generator
// depends on combinatorial_sequence_generator ports
module csg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tlast,
    input logic [1:0]  m_tuser,
    input logic [39:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && m_tdata == 40'd0)
        else $error("error result malformed");
    a_err_nowrap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("error with wrap");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("ready mid run");
endmodule

bind combinatorial_sequence_generator csg_checker u_csg_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
    .m_tuser(m_tuser), .m_tdata(m_tdata)
);

@@ test/tb.sv @@
// testbench for combinatorial_sequence_generator: streams requests, predicts each run
// with a scoreboard class and checks every result field. depends on csg_pkg and the rtl
module tb;
    import csg_pkg::*;

    class arrangement_scoreboard;
        logic [1:0]  mode;
        int          n_items;
        int          n_picks;
        int          pos [MAX_PICKS_DEF];
        bit          dir [MAX_PICKS_DEF];
        int          mob;
        logic [31:0] values [MAX_ITEMS_DEF];
        result_t     runs_due [$];
        int          mismatches;

        function new();
            mode = MODE_WORDS;
            n_items = 2;
            n_picks = 1;
            mismatches = 0;
            foreach (values[i]) values[i] = '0;
            first_arrangement();
        endfunction

        function bit config_valid();
            if (n_items == 0 || n_picks == 0) return 0;
            if (n_items > MAX_ITEMS_DEF || n_picks > MAX_PICKS_DEF) return 0;
            if ((mode == MODE_PERM || mode == MODE_COMB) && n_picks > n_items) return 0;
            return 1;
        endfunction

        function void first_arrangement();
            foreach (pos[i]) begin
                pos[i] = 0;
                dir[i] = 0;
            end
            mob = 0;
            if (!config_valid()) return;
            if (mode == MODE_PERM || mode == MODE_COMB)
                for (int i = 0; i < n_picks; i++) pos[i] = i;
            mob = n_picks - 1;
        endfunction

        function void write_reg(logic [1:0] idx, logic [4:0] data);
            if (idx == CFG_MODE) mode = data[1:0];
            else if (idx == CFG_ITEMS) n_items = data;
            else if (idx == CFG_PICKS) n_picks = data[3:0];
            else return;
            first_arrangement();
        endfunction

        function bit next_word();
            for (int i = n_picks - 1; i >= 0; i--) begin
                if (pos[i] + 1 < n_items) begin
                    pos[i]++;
                    return 0;
                end
                pos[i] = 0;
            end
            return 1;
        endfunction

        function bit advance_comb();
            for (int i = n_picks - 1; i >= 0; i--) begin
                if (pos[i] < n_items - n_picks + i) begin
                    pos[i]++;
                    for (int j = i + 1; j < n_picks; j++) pos[j] = pos[j-1] + 1;
                    return 0;
                end
            end
            for (int i = 0; i < n_picks; i++) pos[i] = i;
            return 1;
        endfunction

        function bit next_multi();
            for (int i = n_picks - 1; i >= 0; i--) begin
                if (pos[i] + 1 < n_items) begin
                    pos[i]++;
                    for (int j = i + 1; j < n_picks; j++) pos[j] = pos[i];
                    return 0;
                end
            end
            for (int i = 0; i < n_picks; i++) pos[i] = 0;
            return 1;
        endfunction

        function bit advance_perm();
            int k, it, tgt, moved, tmp, grt, best, nb, v, j;
            bit fin, td, inr;
            k = n_picks;
            it = mob;
            tgt = 0;
            fin = (k < 2) || (it >= k);
            if (!fin) begin
                if (dir[it]) begin
                    tgt = it + 1;
                    if (tgt >= k) fin = 1;
                end else if (it == 0) begin
                    fin = 1;
                end else begin
                    tgt = it - 1;
                end
            end
            if (!fin) begin
                moved = pos[it];
                tmp = pos[it]; pos[it] = pos[tgt]; pos[tgt] = tmp;
                td = dir[it]; dir[it] = dir[tgt]; dir[tgt] = td;
                grt = 0;
                best = n_items;
                for (int i = 0; i < k; i++) begin
                    if (pos[i] > moved) dir[i] = !dir[i];
                    if (dir[i]) begin
                        nb = i + 1;
                        inr = nb < k;
                    end else begin
                        inr = i > 0;
                        nb = inr ? i - 1 : 0;
                    end
                    if (inr && pos[i] >= grt && pos[i] > pos[nb]) begin
                        grt = pos[i];
                        best = i;
                    end
                end
                mob = best;
                return 0;
            end
            for (int i = 1; i < k; i++) begin
                v = pos[i];
                j = i;
                while (j > 0 && pos[j-1] > v) begin
                    pos[j] = pos[j-1];
                    j--;
                end
                pos[j] = v;
            end
            fin = advance_comb();
            foreach (dir[i]) dir[i] = 0;
            mob = k - 1;
            return fin;
        endfunction

        function void note_request(logic [1:0] req, logic [3:0] idx, logic [31:0] val);
            result_t r;
            bit wrap;
            wrap = 0;
            if (req == REQ_WRITE) begin
                values[idx] = val;
                return;
            end
            if (req == REQ_NONE) return;
            if (!config_valid()) begin
                r = '0;
                r.last = 1;
                r.error = 1;
                runs_due.push_back(r);
                return;
            end
            if (req == REQ_RESTART) first_arrangement();
            else case (mode)
                MODE_WORDS: wrap = next_word();
                MODE_PERM:  wrap = advance_perm();
                MODE_COMB:  wrap = advance_comb();
                default:    wrap = next_multi();
            endcase
            for (int i = 0; i < n_picks; i++) begin
                r.position_index = 4'(pos[i]);
                r.item_value = values[pos[i]];
                r.last = (i + 1 == n_picks);
                r.wrapped = wrap;
                r.error = 0;
                runs_due.push_back(r);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (runs_due.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                mismatches++;
                return;
            end
            want = runs_due.pop_front();
            if (got.position_index !== want.position_index || got.item_value !== want.item_value
                || got.last !== want.last || got.wrapped !== want.wrapped
                || got.error !== want.error) begin
                $display("%0t: mismatch expected idx %0d val %h last %b wrap %b err %b",
                         $time, want.position_index, want.item_value, want.last,
                         want.wrapped, want.error);
                $display("%0t:          actual   idx %0d val %h last %b wrap %b err %b",
                         $time, got.position_index, got.item_value, got.last,
                         got.wrapped, got.error);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [4:0]  cfg_data = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    arrangement_scoreboard sb = new();
    int results_seen = 0;
    int quiet_cycles = 0;

    combinatorial_sequence_generator dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.position_index = m_tdata[3:0];
            got.item_value = m_tdata[35:4];
            got.last = m_tlast;
            got.wrapped = m_tuser[0];
            got.error = m_tuser[1];
            sb.check_result(got);
            results_seen++;
        end
    end

    // receiver: random stalls, ready stretches, one long hold-off
    initial begin
        int pct;
        bit held;
        pct = 100;
        held = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= 60) begin
                held = 1;
                m_tready <= 0;
                repeat (400) @(negedge aclk);
            end else if ($urandom_range(0, 99) < 2) begin
                m_tready <= 0;
                repeat ($urandom_range(15, 50)) @(negedge aclk);
            end else begin
                if ($urandom_range(0, 63) == 0) pct = ($urandom_range(0, 1)) ? 100 : 60;
                m_tready <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_request(logic [1:0] req, logic [3:0] idx, logic [31:0] val);
        int gap;
        s_tvalid <= 1;
        s_tdata <= {2'b0, val, idx, req};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(req, idx, val);
        @(negedge aclk);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic set_config(logic [1:0] md, logic [4:0] items, logic [4:0] picks);
        s_tvalid <= 0;
        while (sb.runs_due.size() > 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= CFG_MODE;
        cfg_data <= {3'b0, md};
        @(negedge aclk);
        sb.write_reg(CFG_MODE, {3'b0, md});
        cfg_index <= CFG_ITEMS;
        cfg_data <= items;
        @(negedge aclk);
        sb.write_reg(CFG_ITEMS, items);
        cfg_index <= CFG_PICKS;
        cfg_data <= picks;
        @(negedge aclk);
        sb.write_reg(CFG_PICKS, picks);
        cfg_we <= 0;
        @(negedge aclk);
    endtask

    initial begin
        int r, items, picks;
        logic [1:0] req;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // fill the whole value table first, with extreme values in it
        for (int i = 0; i < MAX_ITEMS_DEF; i++)
            send_request(REQ_WRITE, 4'(i), (i == 0) ? 32'h8000_0000 :
                                           (i == 1) ? 32'h7fff_ffff :
                                           (i == 2) ? 32'hffff_ffff : $urandom());
        send_request(REQ_ADVANCE, 4'd0, 32'd0);
        send_request(REQ_NONE, 4'hf, 32'hffff_ffff);
        send_request(REQ_RESTART, 4'd0, 32'd0);
        set_config(MODE_PERM, 5'd3, 5'd4);
        send_request(REQ_ADVANCE, 4'd0, 32'd0);
        set_config(MODE_WORDS, 5'd0, 5'd2);
        send_request(REQ_RESTART, 4'd0, 32'd0);
        set_config(MODE_MULTI, 5'd4, 5'd0);
        send_request(REQ_ADVANCE, 4'd0, 32'd0);
        set_config(MODE_PERM, 5'd16, 5'd8);
        repeat (3) send_request(REQ_ADVANCE, 4'd0, 32'd0);
        // random phases, small sizes mostly so sequences wrap
        for (int ph = 0; ph < 16; ph++) begin
            items = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 5);
            picks = ($urandom_range(0, 7) == 0) ? 8 : $urandom_range(1, 4);
            if ($urandom_range(0, 15) == 0) items = 0;
            if ($urandom_range(0, 15) == 0) picks = 0;
            set_config(2'($urandom_range(0, 3)), 5'(items), 5'(picks));
            repeat (18) begin
                r = $urandom_range(0, 99);
                req = (r < 80) ? REQ_ADVANCE : (r < 88) ? REQ_RESTART :
                      (r < 96) ? REQ_WRITE : REQ_NONE;
                send_request(req, 4'($urandom_range(0, 15)), $urandom());
            end
        end
        s_tvalid <= 0;
        while (sb.runs_due.size() > 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
        if (sb.mismatches == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule

@@ combinatorial_sequence_generator.f @@
src/csg_pkg.sv
src/csg_engine.sv
src/combinatorial_sequence_generator.sv
src/csg_checker.sv
test/tb.sv
